### sv/lppm_pkg.sv
package lppm_pkg;

  // Word field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 64;
  localparam int COUNT_W  = 9;

  // Default geometry
  localparam int INDEX_BITS_DEF = 8;
  localparam int KEY_BITS_DEF   = 64;
  localparam int DATA_BITS_DEF  = 64;

  // Home slot hash shifts
  localparam int HASH_SH0 = 2;
  localparam int HASH_SH1 = 6;
  localparam int HASH_SH2 = 10;
  localparam int HASH_SH3 = 14;

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_FOUND    = 3'd0,
    STS_MISSED   = 3'd1,
    STS_INSERTED = 3'd2,
    STS_UPDATED  = 3'd3,
    STS_FULL     = 3'd4,
    STS_REMOVED  = 3'd5,
    STS_REJECTED = 3'd6,
    STS_CLEARED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_PRESENT = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ISSUE,
    ST_PROBE,
    ST_WRITE,
    ST_CLEAR,
    ST_REPLY
  } fsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic sweep;
    logic write;
    logic reply;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic reject;
    logic probe_end;
    logic probe_write;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

### sv/lppm_if.sv
interface lppm_in_if;
  logic                          valid;
  logic                          ready;
  logic [lppm_pkg::OP_W-1:0]     op;
  logic [lppm_pkg::KEY_W-1:0]    key;
  logic [lppm_pkg::VALUE_W-1:0]  value;
  logic [lppm_pkg::SLOT_W-1:0]   slot_in;

  modport source (output valid, output op, output key, output value, output slot_in,
                  input ready);
  modport sink (input valid, input op, input key, input value, input slot_in,
                output ready);
endinterface

interface lppm_out_if;
  logic                           valid;
  logic                           ready;
  logic [lppm_pkg::STATUS_W-1:0]  status;
  logic [lppm_pkg::SLOT_W-1:0]    slot_out;
  logic [lppm_pkg::DATA_W-1:0]    data_out;
  logic [lppm_pkg::COUNT_W-1:0]   live_count;
  logic [lppm_pkg::COUNT_W-1:0]   tomb_count;

  modport source (output valid, output status, output slot_out, output data_out,
                  output live_count, output tomb_count, input ready);
  modport sink (input valid, input status, input slot_out, input data_out,
                input live_count, input tomb_count, output ready);
endinterface

### sv/lppm_ram.sv
module lppm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/lppm_ctrl.sv
module lppm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lppm_pkg::stat_t stat,
  output lppm_pkg::cmd_t  cmd
);

  lppm_pkg::fsm_state_t state_r, state_nxt;

  // State register; reset starts the table sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lppm_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lppm_pkg::ST_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = lppm_pkg::ST_IDLE;
        end
      end
      lppm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = lppm_pkg::ST_ISSUE;
        end
      end
      lppm_pkg::ST_ISSUE: begin
        cmd.start = 1'b1;
        if (stat.is_clear) begin
          state_nxt = lppm_pkg::ST_CLEAR;
        end else if (stat.reject) begin
          state_nxt = lppm_pkg::ST_REPLY;
        end else begin
          state_nxt = lppm_pkg::ST_PROBE;
        end
      end
      lppm_pkg::ST_PROBE: begin
        cmd.step = 1'b1;
        if (stat.probe_end) begin
          state_nxt = stat.probe_write ? lppm_pkg::ST_WRITE : lppm_pkg::ST_REPLY;
        end
      end
      lppm_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = lppm_pkg::ST_REPLY;
      end
      lppm_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = lppm_pkg::ST_REPLY;
        end
      end
      lppm_pkg::ST_REPLY: begin
        if (stat.out_free) begin
          cmd.reply = 1'b1;
          state_nxt = lppm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lppm_pkg::ST_INIT;
      end
    endcase
  end

endmodule

### sv/lppm_datapath.sv
module lppm_datapath #(
  parameter int INDEX_BITS = lppm_pkg::INDEX_BITS_DEF,
  parameter int KEY_BITS   = lppm_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS  = lppm_pkg::DATA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lppm_pkg::cmd_t                  cmd,
  output lppm_pkg::stat_t                 stat,
  input  logic [lppm_pkg::OP_W-1:0]       in_op,
  input  logic [lppm_pkg::KEY_W-1:0]      in_key,
  input  logic [lppm_pkg::VALUE_W-1:0]    in_value,
  input  logic [lppm_pkg::SLOT_W-1:0]     in_slot_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lppm_pkg::STATUS_W-1:0]   out_status,
  output logic [lppm_pkg::SLOT_W-1:0]     out_slot_out,
  output logic [lppm_pkg::DATA_W-1:0]     out_data_out,
  output logic [lppm_pkg::COUNT_W-1:0]    out_live_count,
  output logic [lppm_pkg::COUNT_W-1:0]    out_tomb_count
);

  localparam int DEPTH  = 1 << INDEX_BITS;
  localparam int CW     = INDEX_BITS + 1;
  localparam int ENTRY  = 2 + KEY_BITS + DATA_BITS;

  // Registered request
  lppm_pkg::op_t           op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [DATA_BITS-1:0]    val_r;
  logic [lppm_pkg::SLOT_W-1:0] slot_r;

  // Probe walk
  logic [INDEX_BITS-1:0]   probe_r;
  logic [INDEX_BITS-1:0]   cnt_r;
  logic                    have_avail_r;
  logic [INDEX_BITS-1:0]   avail_r;
  logic                    avail_del_r;

  // Pending result and write-back
  lppm_pkg::status_t       res_status_r;
  logic [INDEX_BITS-1:0]   res_slot_r;
  logic [DATA_BITS-1:0]    res_data_r;
  logic [INDEX_BITS-1:0]   wr_addr_r;
  lppm_pkg::slot_state_t   wr_state_r;
  logic [KEY_BITS-1:0]     wr_key_r;
  logic [DATA_BITS-1:0]    wr_data_r;

  // Occupancy counts
  logic [CW-1:0]           live_r, live_nxt;
  logic [CW-1:0]           tomb_r, tomb_nxt;

  // Output word
  logic                        out_valid_r;
  lppm_pkg::status_t           out_status_r;
  logic [lppm_pkg::SLOT_W-1:0] out_slot_r;
  logic [lppm_pkg::DATA_W-1:0] out_data_r;
  logic [lppm_pkg::COUNT_W-1:0] out_live_r;
  logic [lppm_pkg::COUNT_W-1:0] out_tomb_r;

  // Table memory: {state, key, data}
  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [ENTRY-1:0]        ram_wdata;
  logic [INDEX_BITS-1:0]   ram_raddr;
  logic [ENTRY-1:0]        ram_rdata;
  logic [1:0]              rd_state;
  logic [KEY_BITS-1:0]     rd_key;
  logic [DATA_BITS-1:0]    rd_data;

  // Address and check helpers
  logic [KEY_BITS+63:0]        key_ext;
  logic [63:0]                 key64;
  logic [63:0]                 hash64;
  logic [INDEX_BITS-1:0]       home;
  logic [INDEX_BITS+7:0]       slot_ext;
  logic [INDEX_BITS-1:0]       slot_idx;
  logic                        slot_oor;
  logic [INDEX_BITS-1:0]       start_addr;
  logic                        hit;
  logic                        is_free;
  logic                        last;

  // Probe verdict
  logic                        pr_end;
  logic                        pr_write;
  lppm_pkg::status_t           pr_status;
  logic [INDEX_BITS-1:0]       pr_slot;
  logic [DATA_BITS-1:0]        pr_data;
  logic [INDEX_BITS-1:0]       pr_waddr;
  lppm_pkg::slot_state_t       pr_wstate;
  logic [KEY_BITS-1:0]         pr_wkey;
  logic [DATA_BITS-1:0]        pr_wdata;
  logic                        ins_any;
  logic                        ins_del;

  // Widening for the output word
  logic [INDEX_BITS+7:0]       oslot_ext;
  logic [DATA_BITS+63:0]       odata_ext;
  logic [CW+8:0]               olive_ext;
  logic [CW+8:0]               otomb_ext;

  lppm_ram #(
    .WIDTH (ENTRY),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_state = ram_rdata[ENTRY-1 -: 2];
  assign rd_key   = ram_rdata[DATA_BITS +: KEY_BITS];
  assign rd_data  = ram_rdata[DATA_BITS-1:0];

  // Home slot: key xor-folded at four shifts
  assign key_ext = {64'(0), key_r};
  assign key64   = key_ext[63:0];
  assign hash64  = (key64 >> lppm_pkg::HASH_SH0) ^ (key64 >> lppm_pkg::HASH_SH1) ^
                   (key64 >> lppm_pkg::HASH_SH2) ^ (key64 >> lppm_pkg::HASH_SH3);
  assign home    = hash64[INDEX_BITS-1:0];

  // Remove target and range check
  assign slot_ext = {INDEX_BITS'(0), slot_r};
  assign slot_idx = slot_ext[INDEX_BITS-1:0];
  assign slot_oor = |(slot_ext >> INDEX_BITS);

  assign start_addr = (op_r == lppm_pkg::OP_REMOVE) ? slot_idx : home;

  // Read ahead one slot so a probe retires each cycle
  assign ram_raddr = cmd.start ? start_addr : probe_r + INDEX_BITS'(1);

  // Write port: sweep frees slots, otherwise pending write-back
  assign ram_we    = cmd.sweep | cmd.write;
  assign ram_waddr = cmd.sweep ? cnt_r : wr_addr_r;
  assign ram_wdata = cmd.sweep ? {lppm_pkg::SLOT_FREE, key_r, val_r}
                               : {wr_state_r, wr_key_r, wr_data_r};

  assign hit     = (rd_state == lppm_pkg::SLOT_PRESENT) && (rd_key == key_r);
  assign is_free = (rd_state == lppm_pkg::SLOT_FREE);
  assign last    = &cnt_r;

  // Verdict on the slot just read
  always_comb begin
    pr_end    = 1'b0;
    pr_write  = 1'b0;
    pr_status = lppm_pkg::STS_MISSED;
    pr_slot   = '0;
    pr_data   = '0;
    pr_waddr  = probe_r;
    pr_wstate = lppm_pkg::SLOT_PRESENT;
    pr_wkey   = key_r;
    pr_wdata  = val_r;
    live_nxt  = live_r;
    tomb_nxt  = tomb_r;
    ins_any   = 1'b0;
    ins_del   = 1'b0;
    case (op_r)
      lppm_pkg::OP_SEARCH: begin
        if (hit) begin
          pr_end    = 1'b1;
          pr_status = lppm_pkg::STS_FOUND;
          pr_slot   = probe_r;
          pr_data   = rd_data;
        end else if (is_free || last) begin
          pr_end    = 1'b1;
        end
      end
      lppm_pkg::OP_INSERT: begin
        if (hit) begin
          pr_end    = 1'b1;
          pr_write  = 1'b1;
          pr_status = lppm_pkg::STS_UPDATED;
          pr_slot   = probe_r;
          pr_data   = val_r;
        end else if (is_free || last) begin
          pr_end = 1'b1;
          if (have_avail_r) begin
            ins_any  = 1'b1;
            ins_del  = avail_del_r;
            pr_waddr = avail_r;
          end else if (rd_state != lppm_pkg::SLOT_PRESENT) begin
            ins_any  = 1'b1;
            ins_del  = (rd_state == lppm_pkg::SLOT_DELETED);
          end
          if (ins_any) begin
            pr_write  = 1'b1;
            pr_status = lppm_pkg::STS_INSERTED;
            pr_slot   = pr_waddr;
            pr_data   = val_r;
            live_nxt  = live_r + CW'(1);
            tomb_nxt  = ins_del ? tomb_r - CW'(1) : tomb_r;
          end else begin
            pr_status = lppm_pkg::STS_FULL;
          end
        end
      end
      lppm_pkg::OP_REMOVE: begin
        pr_end = 1'b1;
        if (rd_state == lppm_pkg::SLOT_PRESENT) begin
          pr_write  = 1'b1;
          pr_wstate = lppm_pkg::SLOT_DELETED;
          pr_wkey   = rd_key;
          pr_wdata  = rd_data;
          pr_status = lppm_pkg::STS_REMOVED;
          pr_slot   = probe_r;
          pr_data   = rd_data;
          live_nxt  = live_r - CW'(1);
          tomb_nxt  = tomb_r + CW'(1);
        end else begin
          pr_status = lppm_pkg::STS_REJECTED;
        end
      end
      default: begin
        pr_end    = 1'b1;
        pr_status = lppm_pkg::STS_CLEARED;
      end
    endcase
  end

  // Status to controller
  assign stat.is_clear    = (op_r == lppm_pkg::OP_CLEAR);
  assign stat.reject      = (((op_r == lppm_pkg::OP_SEARCH) || (op_r == lppm_pkg::OP_INSERT))
                             && (key_r == '0)) ||
                            ((op_r == lppm_pkg::OP_REMOVE) && slot_oor);
  assign stat.probe_end   = pr_end;
  assign stat.probe_write = pr_write;
  assign stat.sweep_last  = last;
  assign stat.out_free    = !out_valid_r || out_ready;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= lppm_pkg::op_t'(in_op);
      key_r  <= in_key[KEY_BITS-1:0];
      val_r  <= in_value[DATA_BITS-1:0];
      slot_r <= in_slot_in;
    end
  end

  // Probe walk, sweep counter and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      have_avail_r <= 1'b0;
      live_r       <= '0;
      tomb_r       <= '0;
    end else if (cmd.start) begin
      cnt_r        <= '0;
      have_avail_r <= 1'b0;
      if (op_r == lppm_pkg::OP_CLEAR) begin
        live_r <= '0;
        tomb_r <= '0;
      end
    end else if (cmd.sweep) begin
      cnt_r <= cnt_r + INDEX_BITS'(1);
    end else if (cmd.step) begin
      if (pr_end) begin
        live_r <= live_nxt;
        tomb_r <= tomb_nxt;
      end else begin
        cnt_r <= cnt_r + INDEX_BITS'(1);
        if (!have_avail_r && (rd_state != lppm_pkg::SLOT_PRESENT)) begin
          have_avail_r <= 1'b1;
        end
      end
    end
  end

  // Probe address, first free or deleted slot, result and write-back
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      probe_r    <= start_addr;
      res_status_r <= (op_r == lppm_pkg::OP_CLEAR) ? lppm_pkg::STS_CLEARED
                                                   : lppm_pkg::STS_REJECTED;
      res_slot_r <= '0;
      res_data_r <= '0;
    end else if (cmd.step) begin
      if (pr_end) begin
        res_status_r <= pr_status;
        res_slot_r   <= pr_slot;
        res_data_r   <= pr_data;
        wr_addr_r    <= pr_waddr;
        wr_state_r   <= pr_wstate;
        wr_key_r     <= pr_wkey;
        wr_data_r    <= pr_wdata;
      end else begin
        probe_r <= probe_r + INDEX_BITS'(1);
        if (!have_avail_r && (rd_state != lppm_pkg::SLOT_PRESENT)) begin
          avail_r     <= probe_r;
          avail_del_r <= (rd_state == lppm_pkg::SLOT_DELETED);
        end
      end
    end
  end

  assign oslot_ext = {8'(0), res_slot_r};
  assign odata_ext = {64'(0), res_data_r};
  assign olive_ext = {9'(0), live_r};
  assign otomb_ext = {9'(0), tomb_r};

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reply) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      out_status_r <= res_status_r;
      out_slot_r   <= oslot_ext[lppm_pkg::SLOT_W-1:0];
      out_data_r   <= odata_ext[lppm_pkg::DATA_W-1:0];
      out_live_r   <= olive_ext[lppm_pkg::COUNT_W-1:0];
      out_tomb_r   <= otomb_ext[lppm_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_data_out   = out_data_r;
  assign out_live_count = out_live_r;
  assign out_tomb_count = out_tomb_r;

  // Occupancy never exceeds the table
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_r} + {1'b0, tomb_r}) <= (CW+1)'(DEPTH))
    else $error("live plus deleted exceeds table size");

  // A walk ends no later than one full lap
  a_lap_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && last) |-> pr_end)
    else $error("probe walk ran past one lap");

  // A result word only appears after a reply command
  a_reply_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.reply))
    else $error("output word raised without reply");

  // Never store a present slot under key zero
  a_no_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && (wr_state_r == lppm_pkg::SLOT_PRESENT)) |-> (wr_key_r != '0))
    else $error("present slot written with zero key");

endmodule

### sv/linear_probe_pointer_map.sv
// Channel  | Dir | Handshake     | Word
// in_chan  | in  | valid / ready | op, key, value, slot_in
// out_chan | out | valid / ready | status, slot_out, data_out, live_count, tomb_count
//
// Search and insert pass issue, a probe and reply states; the probe reads the slots
// in turn (one per cycle through the table RAM's read port); a write adds a write state.
// Remove reads only its given slot; clear frees every slot, one slot freed per cycle.
// After reset the table is swept the same way with in_chan.ready low.
// A finished word waits in the output register; the next word is taken meanwhile.
module linear_probe_pointer_map #(
  parameter int INDEX_BITS = lppm_pkg::INDEX_BITS_DEF,
  parameter int KEY_BITS   = lppm_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS  = lppm_pkg::DATA_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lppm_in_if.sink    in_chan,
  lppm_out_if.source out_chan
);

  lppm_pkg::cmd_t  cmd;
  lppm_pkg::stat_t stat;

  lppm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lppm_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .KEY_BITS   (KEY_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_chan.op),
    .in_key         (in_chan.key),
    .in_value       (in_chan.value),
    .in_slot_in     (in_chan.slot_in),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_status     (out_chan.status),
    .out_slot_out   (out_chan.slot_out),
    .out_data_out   (out_chan.data_out),
    .out_live_count (out_chan.live_count),
    .out_tomb_count (out_chan.tomb_count)
  );

endmodule

### tb/linear_probe_pointer_map_tb.sv
`timescale 1ns / 1ps

module linear_probe_pointer_map_tb;
  import lppm_pkg::*;

  localparam int SLOTS      = 1 << INDEX_BITS_DEF;
  localparam int STALL_MAX  = 4000;
  localparam int SETTLE     = 300;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
  } map_req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  live;
    logic [COUNT_W-1:0]  tomb;
  } map_reply_t;

  logic clk;
  logic rst_n;

  lppm_in_if  in_chan ();
  lppm_out_if out_chan ();

  linear_probe_pointer_map u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the table
  slot_state_t        slot_st  [SLOTS];
  logic [KEY_W-1:0]   key_mem  [SLOTS];
  logic [DATA_W-1:0]  data_mem [SLOTS];
  logic [COUNT_W-1:0] live_n;
  logic [COUNT_W-1:0] tomb_n;

  map_req_t         map_req_q [$];
  map_reply_t       reply_due_q [$];
  logic [KEY_W-1:0] key_pool [$];
  map_req_t         drv_word;
  map_reply_t       want;
  map_reply_t       got;

  bit steady;
  int stall_cycles;
  int faults;
  int sent_n;
  int checked_n;
  int tally [8];

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = (k >> HASH_SH0) ^ (k >> HASH_SH1) ^ (k >> HASH_SH2) ^ (k >> HASH_SH3);
    return h[SLOT_W-1:0];
  endfunction

  function automatic void map_wipe();
    int n;
    for (n = 0; n < SLOTS; n++) slot_st[n] = SLOT_FREE;
    live_n = '0;
    tomb_n = '0;
  endfunction

  // Applies one request to the shadow table and returns the reply it should give
  function automatic map_reply_t map_apply(op_t op, logic [KEY_W-1:0] k,
                                           logic [VALUE_W-1:0] v, logic [SLOT_W-1:0] sl);
    map_reply_t r;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] hole;
    bit have_hole;
    bit done;
    int n;
    r.status  = STS_REJECTED;
    r.slot    = '0;
    r.data    = '0;
    hole      = '0;
    have_hole = 1'b0;
    done      = 1'b0;
    idx       = home_of(k);
    case (op)
      OP_CLEAR: begin
        map_wipe();
        r.status = STS_CLEARED;
      end
      OP_REMOVE: begin
        if (slot_st[sl] == SLOT_PRESENT) begin
          slot_st[sl] = SLOT_DELETED;
          live_n--;
          tomb_n++;
          r.status = STS_REMOVED;
          r.slot   = sl;
          r.data   = data_mem[sl];
        end
      end
      OP_SEARCH: begin
        if (k != '0) begin
          r.status = STS_MISSED;
          for (n = 0; n < SLOTS && !done; n++) begin
            if (slot_st[idx] == SLOT_FREE) begin
              done = 1'b1;
            end else if (slot_st[idx] == SLOT_PRESENT && key_mem[idx] == k) begin
              r.status = STS_FOUND;
              r.slot   = idx;
              r.data   = data_mem[idx];
              done     = 1'b1;
            end
            idx++;
          end
        end
      end
      default: begin
        if (k != '0) begin
          // walk until a free slot or an equal key, noting the first hole
          for (n = 0; n < SLOTS && !done; n++) begin
            if (slot_st[idx] != SLOT_PRESENT) begin
              if (!have_hole) begin
                have_hole = 1'b1;
                hole      = idx;
              end
              if (slot_st[idx] == SLOT_FREE) done = 1'b1;
            end else if (key_mem[idx] == k) begin
              data_mem[idx] = v;
              r.status = STS_UPDATED;
              r.slot   = idx;
              r.data   = v;
              done     = 1'b1;
            end
            idx++;
          end
          if (r.status != STS_UPDATED) begin
            if (!have_hole) begin
              r.status = STS_FULL;
            end else begin
              if (slot_st[hole] == SLOT_DELETED) tomb_n--;
              slot_st[hole]  = SLOT_PRESENT;
              key_mem[hole]  = k;
              data_mem[hole] = v;
              live_n++;
              r.status = STS_INSERTED;
              r.slot   = hole;
              r.data   = v;
            end
          end
        end
      end
    endcase
    r.live = live_n;
    r.tomb = tomb_n;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Nonzero key; narrow keys crowd into few home slots
  function automatic logic [KEY_W-1:0] fresh_key(bit narrow);
    logic [KEY_W-1:0] k;
    k = narrow ? KEY_W'($urandom_range(1, 700)) : rand64();
    if (k == '0) k = 'd1;
    return k;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_live_slot();
    logic [SLOT_W-1:0] idx;
    int n;
    idx = SLOT_W'($urandom);
    for (n = 0; n < SLOTS; n++) begin
      if (slot_st[idx] == SLOT_PRESENT) return idx;
      idx++;
    end
    return idx;
  endfunction

  function automatic logic [KEY_W-1:0] pool_key(bit narrow);
    if (key_pool.size() == 0) return fresh_key(narrow);
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // Keeps a short backlog so the shadow state stays close to the accepted words
  task automatic post(op_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                      logic [SLOT_W-1:0] sl);
    map_req_t w;
    while (map_req_q.size() > 4) @(negedge clk);
    w.op    = op;
    w.key   = k;
    w.value = v;
    w.slot  = sl;
    map_req_q.push_back(w);
  endtask

  // Hold the sender until every reply is back
  task automatic drain();
    while (map_req_q.size() != 0 || in_chan.valid || reply_due_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic post_mixed(bit narrow);
    int roll;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    k    = fresh_key(narrow);
    if (live_n > 200) begin
      post(OP_CLEAR, rand64(), rand64(), SLOT_W'($urandom));
    end else if (roll < 3) begin
      post(roll < 2 ? OP_SEARCH : OP_INSERT, '0, rand64(), SLOT_W'($urandom));
    end else if (roll < 5) begin
      post(OP_CLEAR, rand64(), rand64(), SLOT_W'($urandom));
    end else if (roll < 40) begin
      if ($urandom_range(0, 99) < 40) begin
        k = pool_key(narrow);
      end else begin
        key_pool.push_back(k);
        if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
      post(OP_INSERT, k, rand64(), SLOT_W'($urandom));
    end else if (roll < 75) begin
      if ($urandom_range(0, 99) < 70) k = pool_key(narrow);
      post(OP_SEARCH, k, rand64(), SLOT_W'($urandom));
    end else if (roll < 95) begin
      post(OP_REMOVE, rand64(), rand64(), pick_live_slot());
    end else begin
      post(OP_REMOVE, rand64(), rand64(), SLOT_W'($urandom));
    end
  endtask

  // Driver: predicts on accept, then offers the next word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      map_wipe();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        reply_due_q.push_back(map_apply(op_t'(in_chan.op), in_chan.key, in_chan.value,
                                        in_chan.slot_in));
        sent_n++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (map_req_q.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
          drv_word = map_req_q.pop_front();
          in_chan.valid   <= 1'b1;
          in_chan.op      <= drv_word.op;
          in_chan.key     <= drv_word.key;
          in_chan.value   <= drv_word.value;
          in_chan.slot_in <= drv_word.slot;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each reply against the oldest expectation
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= steady || ($urandom_range(0, 99) >= 20);
      if (out_chan.valid && out_chan.ready) begin
        got.status = status_t'(out_chan.status);
        got.slot   = out_chan.slot_out;
        got.data   = out_chan.data_out;
        got.live   = out_chan.live_count;
        got.tomb   = out_chan.tomb_count;
        tally[out_chan.status]++;
        checked_n++;
        if (reply_due_q.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("%0t unexpected reply: status %0d slot %0d data %h live %0d tomb %0d",
                     $realtime, got.status, got.slot, got.data, got.live, got.tomb);
        end else begin
          want = reply_due_q.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= REPORT_MAX) begin
              $display("%0t reply mismatch: status %0d/%0d slot %0d/%0d data %h/%h",
                       $realtime, want.status, got.status, want.slot, got.slot,
                       want.data, got.data);
              $display("  live %0d/%0d tomb %0d/%0d (expected/actual)",
                       want.live, got.live, want.tomb, got.tomb);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving
  initial begin
    while (stall_cycles < STALL_MAX) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] fill_keys [$];
    logic [KEY_W-1:0] ones;
    logic [KEY_W-1:0] k;
    int i;
    ones  = '1;
    clk   = 1'b0;
    rst_n = 1'b0;
    steady = 1'b0;
    stall_cycles = 0;
    faults = 0;
    sent_n = 0;
    checked_n = 0;
    for (i = 0; i < 8; i++) tally[i] = 0;
    in_chan.valid   = 1'b0;
    in_chan.op      = OP_SEARCH;
    in_chan.key     = '0;
    in_chan.value   = '0;
    in_chan.slot_in = '0;
    out_chan.ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero keys, extreme values, collisions and tombstones
    post(OP_SEARCH, '0, ones, 8'hFF);
    post(OP_INSERT, '0, ones, 8'h00);
    post(OP_INSERT, ones, ones, 8'h00);
    post(OP_INSERT, 64'd1, '0, 8'hFF);
    post(OP_SEARCH, ones, '0, 8'h00);
    // same home slot as the two above, probes past them to a free slot
    post(OP_SEARCH, 64'h8000_0000_0000_0000, ones, 8'h55);
    post(OP_INSERT, ones, 64'hA5A5_5A5A_0F0F_F0F0, 8'hAA);
    // keys 4..7 share home slot 1, which key 1 already holds
    post(OP_INSERT, 64'd4, 64'h1111_1111_1111_1111, 8'h00);
    post(OP_INSERT, 64'd5, 64'h2222_2222_2222_2222, 8'h00);
    post(OP_INSERT, 64'd6, 64'h3333_3333_3333_3333, 8'h00);
    post(OP_REMOVE, '0, '0, 8'd3);
    post(OP_REMOVE, ones, ones, 8'd3);
    post(OP_REMOVE, '0, '0, 8'd255);
    post(OP_SEARCH, 64'd6, '0, 8'h00);
    post(OP_SEARCH, 64'd5, '0, 8'h00);
    post(OP_INSERT, 64'd7, 64'h4444_4444_4444_4444, 8'h00);
    post(OP_INSERT, 64'd4, 64'h0123_4567_89AB_CDEF, 8'h00);
    drain();
    post(OP_CLEAR, rand64(), rand64(), 8'hFF);
    post(OP_SEARCH, 64'd4, '0, 8'h00);
    post(OP_REMOVE, '0, '0, 8'd0);
    post(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFC, '0, 8'h00);
    drain();

    // Mixed traffic with wide keys
    for (i = 0; i < 600; i++) post_mixed(1'b0);

    // Crowded keys, no idling on either side
    steady = 1'b1;
    for (i = 0; i < 200; i++) post_mixed(1'b1);
    drain();
    steady = 1'b0;

    // Fill the table to the brim, then punch holes and refill them
    post(OP_CLEAR, rand64(), rand64(), SLOT_W'($urandom));
    for (i = 0; i < SLOTS; i++) begin
      k = fresh_key(1'b0);
      fill_keys.push_back(k);
      post(OP_INSERT, k, rand64(), SLOT_W'($urandom));
    end
    for (i = 0; i < 6; i++) post(OP_INSERT, fresh_key(1'b0), rand64(), SLOT_W'($urandom));
    for (i = 0; i < 4; i++)
      post(OP_INSERT, fill_keys[$urandom_range(0, SLOTS - 1)], rand64(), SLOT_W'($urandom));
    for (i = 0; i < 8; i++) post(OP_SEARCH, fresh_key(1'b0), rand64(), SLOT_W'($urandom));
    for (i = 0; i < 8; i++)
      post(OP_SEARCH, fill_keys[$urandom_range(0, SLOTS - 1)], rand64(), SLOT_W'($urandom));
    drain();
    for (i = 0; i < 24; i++) post(OP_REMOVE, rand64(), rand64(), pick_live_slot());
    for (i = 0; i < 24; i++) post(OP_INSERT, fresh_key(1'b0), rand64(), SLOT_W'($urandom));
    for (i = 0; i < 10; i++)
      post(OP_SEARCH, fill_keys[$urandom_range(0, SLOTS - 1)], rand64(), SLOT_W'($urandom));
    drain();

    // Tombstone churn on crowded keys
    for (i = 0; i < 280; i++) post_mixed(1'b1);

    drain();
    repeat (SETTLE) @(posedge clk);
    faults += reply_due_q.size();

    $display("Sent %0d requests and checked %0d replies; %0d faults.",
             sent_n, checked_n, faults);
    $display("Replies seen: found %0d, missed %0d, inserted %0d, updated %0d,",
             tally[STS_FOUND], tally[STS_MISSED], tally[STS_INSERTED], tally[STS_UPDATED]);
    $display("  full %0d, removed %0d, rejected %0d, cleared %0d",
             tally[STS_FULL], tally[STS_REMOVED], tally[STS_REJECTED], tally[STS_CLEARED]);
    if (faults == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### linear_probe_pointer_map.f
sv/lppm_pkg.sv
sv/lppm_if.sv
sv/lppm_ram.sv
sv/lppm_ctrl.sv
sv/lppm_datapath.sv
sv/linear_probe_pointer_map.sv
tb/linear_probe_pointer_map_tb.sv
